@@ src/drp_pkg.sv @@
// shared types, codes and the microcode program of the ramp phase generator
`timescale 1ns / 1ps

package drp_pkg;

   localparam int TIME_BITS_DEF  = 24;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int ELAPSED_BITS   = 16;
   localparam int KIND_BITS      = 2;
   localparam int MODE_BITS      = 2;
   localparam int CSR_INDEX_BITS = 2;
   localparam int STEP_BITS      = 5;

   // command kinds
   localparam logic [KIND_BITS-1:0] KIND_TICK    = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_START   = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_RESTART = 2'd2;
   localparam logic [KIND_BITS-1:0] KIND_FINISH  = 2'd3;

   // repeat modes, the unused code behaves as once
   localparam logic [MODE_BITS-1:0] MODE_ONCE = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_LOOP = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_PING = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_RAMP_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_START_WAIT  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_REPEAT_MODE = 2'd2;

   typedef logic [STEP_BITS-1:0] step_type;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_START,
      OP_FINISH,
      OP_USE_WAIT,
      OP_ONCE,
      OP_ZERO,
      OP_LOOP_LOAD,
      OP_DIV_STEP,
      OP_LOOP_END,
      OP_CLAMP,
      OP_PP_FWD,
      OP_PP_BACK,
      OP_PP_END,
      OP_PROG_SETUP,
      OP_PROG_END,
      OP_EMIT
   } op_type;

   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_FIRE,
      C_TICK,
      C_FINISH,
      C_IDLE_TICK,
      C_DT_ZERO,
      C_LEN_ZERO,
      C_LOOP,
      C_PING,
      C_REV,
      C_FWD_FITS,
      C_BACK_FITS,
      C_DIV_MORE,
      C_PROG_DIRECT,
      C_OUT_FREE
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   // datapath status seen by the sequencer
   typedef struct packed {
      logic fire;
      logic kind_tick;
      logic kind_finish;
      logic idle_tick;
      logic dt_zero;
      logic len_zero;
      logic mode_loop;
      logic mode_ping;
      logic rev;
      logic fwd_fits;
      logic back_fits;
      logic div_more;
      logic prog_direct;
      logic out_free;
   } flags_type;

   // program labels
   localparam step_type S_IDLE      = 5'd0;
   localparam step_type S_FIN       = 5'd4;
   localparam step_type S_TICK      = 5'd5;
   localparam step_type S_ZERO      = 5'd12;
   localparam step_type S_LOOP      = 5'd13;
   localparam step_type S_LOOP_DIV  = 5'd14;
   localparam step_type S_PING      = 5'd16;
   localparam step_type S_PP_BACK   = 5'd20;
   localparam step_type S_PP_DIV    = 5'd21;
   localparam step_type S_PROG      = 5'd23;
   localparam step_type S_PROG_DIV  = 5'd24;
   localparam step_type S_EMIT      = 5'd26;

   function automatic ctrl_word_type ucode(step_type s);
      ctrl_word_type w;
      case (s)
         5'd0:  w = '{OP_ACCEPT,     C_NO_FIRE,     S_IDLE};
         5'd1:  w = '{OP_NOP,        C_TICK,        S_TICK};
         5'd2:  w = '{OP_NOP,        C_FINISH,      S_FIN};
         5'd3:  w = '{OP_START,      C_ALWAYS,      S_PROG};
         5'd4:  w = '{OP_FINISH,     C_ALWAYS,      S_PROG};
         5'd5:  w = '{OP_NOP,        C_IDLE_TICK,   S_PROG};
         5'd6:  w = '{OP_USE_WAIT,   C_NEVER,       S_IDLE};
         5'd7:  w = '{OP_NOP,        C_DT_ZERO,     S_PROG};
         5'd8:  w = '{OP_NOP,        C_LEN_ZERO,    S_ZERO};
         5'd9:  w = '{OP_NOP,        C_LOOP,        S_LOOP};
         5'd10: w = '{OP_NOP,        C_PING,        S_PING};
         5'd11: w = '{OP_ONCE,       C_ALWAYS,      S_PROG};
         5'd12: w = '{OP_ZERO,       C_ALWAYS,      S_PROG};
         5'd13: w = '{OP_LOOP_LOAD,  C_NEVER,       S_IDLE};
         5'd14: w = '{OP_DIV_STEP,   C_DIV_MORE,    S_LOOP_DIV};
         5'd15: w = '{OP_LOOP_END,   C_ALWAYS,      S_PROG};
         5'd16: w = '{OP_CLAMP,      C_NEVER,       S_IDLE};
         5'd17: w = '{OP_NOP,        C_REV,         S_PP_BACK};
         5'd18: w = '{OP_PP_FWD,     C_FWD_FITS,    S_PROG};
         5'd19: w = '{OP_NOP,        C_ALWAYS,      S_PP_DIV};
         5'd20: w = '{OP_PP_BACK,    C_BACK_FITS,   S_PROG};
         5'd21: w = '{OP_DIV_STEP,   C_DIV_MORE,    S_PP_DIV};
         5'd22: w = '{OP_PP_END,     C_ALWAYS,      S_PROG};
         5'd23: w = '{OP_PROG_SETUP, C_PROG_DIRECT, S_EMIT};
         5'd24: w = '{OP_DIV_STEP,   C_DIV_MORE,    S_PROG_DIV};
         5'd25: w = '{OP_PROG_END,   C_NEVER,       S_IDLE};
         5'd26: w = '{OP_EMIT,       C_OUT_FREE,    S_IDLE};
         5'd27: w = '{OP_NOP,        C_ALWAYS,      S_EMIT};
         default: w = '{OP_NOP,      C_ALWAYS,      S_IDLE};
      endcase
      return w;
   endfunction

endpackage

@@ src/drp_channels.sv @@
// request and response channel interfaces
`timescale 1ns / 1ps

interface drp_req_if;
   logic                                valid;
   logic                                ready;
   logic [drp_pkg::KIND_BITS-1:0]       kind;
   logic [drp_pkg::ELAPSED_BITS-1:0]    elapsed;

   modport source (output valid, output kind, output elapsed, input ready);
   modport sink   (input valid, input kind, input elapsed, output ready);
endinterface

interface drp_rsp_if #(
   parameter int TIME_BITS = drp_pkg::TIME_BITS_DEF,
   parameter int FRAC_BITS = drp_pkg::FRAC_BITS_DEF
);
   logic                 valid;
   logic                 ready;
   logic [FRAC_BITS:0]   progress;
   logic [TIME_BITS-1:0] position_ticks;
   logic                 going_back;
   logic                 is_running;
   logic                 has_started;

   modport source (output valid, output progress, output position_ticks,
                   output going_back, output is_running, output has_started,
                   input ready);
   modport sink   (input valid, input progress, input position_ticks,
                   input going_back, input is_running, input has_started,
                   output ready);
endinterface

@@ src/drp_divider.sv @@
// restoring serial divider, one quotient bit per cycle while step is high
`timescale 1ns / 1ps

module drp_divider #(
   parameter int NUM_BITS = 40,
   parameter int DEN_BITS = drp_pkg::TIME_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic                step,
   input  logic [NUM_BITS-1:0] num,
   input  logic [DEN_BITS-1:0] den,
   output logic [NUM_BITS-1:0] quo,
   output logic [DEN_BITS-1:0] rem,
   output logic                more
);

   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [NUM_BITS-1:0] quo_ff, quo_in;
   logic [DEN_BITS-1:0] rem_ff, rem_in;
   logic [DEN_BITS:0]   trial;
   logic [DEN_BITS:0]   diff;
   logic                ge;

   assign trial = {rem_ff, quo_ff[NUM_BITS-1]};
   assign ge    = trial >= {1'b0, den};
   assign diff  = trial - {1'b0, den};

   always_comb begin
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      if (load) begin
         cnt_in = CNT_BITS'(NUM_BITS);
         quo_in = num;
         rem_in = '0;
      end else if (step) begin
         cnt_in = cnt_ff - 1'b1;
         quo_in = {quo_ff[NUM_BITS-2:0], ge};
         rem_in = ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign quo  = quo_ff;
   assign rem  = rem_ff;
   assign more = cnt_ff > CNT_BITS'(1);

endmodule

@@ src/drp_sequencer.sv @@
// step counter, microcode lookup and conditional jumps
`timescale 1ns / 1ps

module drp_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  drp_pkg::flags_type     flags,
   output drp_pkg::ctrl_word_type ctrl
);

   drp_pkg::step_type step_ff, step_in;
   logic              taken;

   assign ctrl = drp_pkg::ucode(step_ff);

   always_comb begin
      case (ctrl.cond)
         drp_pkg::C_NEVER:       taken = 1'b0;
         drp_pkg::C_ALWAYS:      taken = 1'b1;
         drp_pkg::C_NO_FIRE:     taken = !flags.fire;
         drp_pkg::C_TICK:        taken = flags.kind_tick;
         drp_pkg::C_FINISH:      taken = flags.kind_finish;
         drp_pkg::C_IDLE_TICK:   taken = flags.idle_tick;
         drp_pkg::C_DT_ZERO:     taken = flags.dt_zero;
         drp_pkg::C_LEN_ZERO:    taken = flags.len_zero;
         drp_pkg::C_LOOP:        taken = flags.mode_loop;
         drp_pkg::C_PING:        taken = flags.mode_ping;
         drp_pkg::C_REV:         taken = flags.rev;
         drp_pkg::C_FWD_FITS:    taken = flags.fwd_fits;
         drp_pkg::C_BACK_FITS:   taken = flags.back_fits;
         drp_pkg::C_DIV_MORE:    taken = flags.div_more;
         drp_pkg::C_PROG_DIRECT: taken = flags.prog_direct;
         drp_pkg::C_OUT_FREE:    taken = flags.out_free;
         default:                taken = 1'b0;
      endcase
   end

   assign step_in = taken ? ctrl.target : step_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= drp_pkg::S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

@@ src/delayed_ramp_phase_generator_core.sv @@
// top level: ramp phase generator datapath around a microcoded sequencer
`timescale 1ns / 1ps

// channel    dir  handshake        payload
// req_chan   in   valid / ready    kind, elapsed
// rsp_chan   out  valid / ready    progress, position_ticks, going_back,
//                                  is_running, has_started
// csr_*      in   csr_write        csr_index, csr_data (no read-back)
//
// one transaction at a time. start, restart and tick may run the progress scaling
// through the serial divider (one quotient bit per cycle over NUM_BITS =
// max(TIME_BITS+FRAC_BITS, max(TIME_BITS,16)+1) bits, 40 by default), and a tick
// may run a loop wrap or a ping-pong bounce through it first. reset is synchronous
// and clears the ramp state, the configuration and the response valid to zero. a
// result waits in the output register while the next request is taken; only a
// second result held by rsp_chan.ready stalls.

module delayed_ramp_phase_generator_core #(
   parameter int TIME_BITS = drp_pkg::TIME_BITS_DEF,
   parameter int FRAC_BITS = drp_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   drp_req_if.sink                               req_chan,
   drp_rsp_if.source                             rsp_chan,
   input  logic                                  csr_write,
   input  logic [drp_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [TIME_BITS-1:0]                  csr_data
);

   localparam int EB       = drp_pkg::ELAPSED_BITS;
   // sums of position and elapsed ticks
   localparam int SUM_BITS = ((TIME_BITS > EB) ? TIME_BITS : EB) + 1;
   localparam int PRG_BITS = TIME_BITS + FRAC_BITS;
   localparam int NUM_BITS = (PRG_BITS > SUM_BITS) ? PRG_BITS : SUM_BITS;
   localparam int TB1      = TIME_BITS + 1;

   // configuration
   logic [TIME_BITS-1:0]           len_ff;
   logic [TIME_BITS-1:0]           wcfg_ff;
   logic [drp_pkg::MODE_BITS-1:0]  mode_ff;

   // ramp state
   logic [TIME_BITS-1:0] pos_ff, pos_in;
   logic [TIME_BITS-1:0] wait_ff, wait_in;
   logic                 rev_ff, rev_in;
   logic                 act_ff, act_in;
   logic                 begun_ff, begun_in;

   // per-transaction working registers
   logic [drp_pkg::KIND_BITS-1:0] kind_ff, kind_in;
   logic [EB-1:0]                 dt_ff, dt_in;
   logic                          fb_ff, fb_in;     // first leg heads to zero
   logic [FRAC_BITS:0]            prog_ff, prog_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [FRAC_BITS:0]   rsp_prog_ff;
   logic [TIME_BITS-1:0] rsp_pos_ff;
   logic                 rsp_back_ff, rsp_run_ff, rsp_begun_ff;
   logic                 rsp_load;

   drp_pkg::ctrl_word_type ctrl;
   drp_pkg::flags_type     flags;

   logic                fire;
   logic [SUM_BITS-1:0] pos_x, dt_x, len_x, wait_x, sum_x, used_x;
   logic                fwd_fits, back_fits, prog_direct, out_free;
   logic [TIME_BITS-1:0] wait_new;
   logic                 start_live;
   logic [TB1-1:0]       refl_r;
   logic                 refl_back;

   // divider hookup
   logic                 div_load, div_step, div_more;
   logic [NUM_BITS-1:0]  div_num, div_quo;
   logic [TIME_BITS-1:0] div_rem;

   drp_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   drp_divider #(
      .NUM_BITS (NUM_BITS),
      .DEN_BITS (TIME_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .load  (div_load),
      .step  (div_step),
      .num   (div_num),
      .den   (len_ff),
      .quo   (div_quo),
      .rem   (div_rem),
      .more  (div_more)
   );

   // handshake
   assign req_chan.ready = (ctrl.op == drp_pkg::OP_ACCEPT);
   assign fire           = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // shared arithmetic
   assign pos_x     = SUM_BITS'(pos_ff);
   assign dt_x      = SUM_BITS'(dt_ff);
   assign len_x     = SUM_BITS'(len_ff);
   assign wait_x    = SUM_BITS'(wait_ff);
   assign sum_x     = pos_x + dt_x;
   assign used_x    = (wait_x < dt_x) ? wait_x : dt_x;
   assign fwd_fits  = sum_x <= len_x;
   assign back_fits = dt_x <= pos_x;
   assign prog_direct = !begun_ff || (pos_ff >= len_ff);

   // start versus restart: only start loads the delay
   assign wait_new   = (kind_ff == drp_pkg::KIND_START) ? wcfg_ff : '0;
   assign start_live = (len_ff != '0) || (wait_new != '0);

   // ping-pong landing point: r in (0, dur], odd leg count flips direction
   assign refl_r    = TB1'(div_rem) + TB1'(1);
   assign refl_back = div_quo[0] ? !fb_ff : fb_ff;

   always_comb begin
      flags.fire        = fire;
      flags.kind_tick   = (kind_ff == drp_pkg::KIND_TICK);
      flags.kind_finish = (kind_ff == drp_pkg::KIND_FINISH);
      flags.idle_tick   = !act_ff || (dt_ff == '0);
      flags.dt_zero     = (dt_ff == '0);
      flags.len_zero    = (len_ff == '0);
      flags.mode_loop   = (mode_ff == drp_pkg::MODE_LOOP);
      flags.mode_ping   = (mode_ff == drp_pkg::MODE_PING);
      flags.rev         = rev_ff;
      flags.fwd_fits    = fwd_fits;
      flags.back_fits   = back_fits;
      flags.div_more    = div_more;
      flags.prog_direct = prog_direct;
      flags.out_free    = out_free;
   end

   // divider operand and control
   always_comb begin
      case (ctrl.op)
         drp_pkg::OP_LOOP_LOAD:  div_num = NUM_BITS'(sum_x);
         drp_pkg::OP_PP_FWD:     div_num = NUM_BITS'(sum_x - len_x - SUM_BITS'(1));
         drp_pkg::OP_PP_BACK:    div_num = NUM_BITS'(dt_x - pos_x - SUM_BITS'(1));
         drp_pkg::OP_PROG_SETUP: div_num = NUM_BITS'({pos_ff, {FRAC_BITS{1'b0}}});
         default:                div_num = '0;
      endcase
   end

   assign div_load = (ctrl.op == drp_pkg::OP_LOOP_LOAD)
                  || ((ctrl.op == drp_pkg::OP_PP_FWD) && !fwd_fits)
                  || ((ctrl.op == drp_pkg::OP_PP_BACK) && !back_fits)
                  || ((ctrl.op == drp_pkg::OP_PROG_SETUP) && !prog_direct);
   assign div_step = (ctrl.op == drp_pkg::OP_DIV_STEP);

   // datapath next state, one microcode op per cycle
   always_comb begin
      pos_in   = pos_ff;
      wait_in  = wait_ff;
      rev_in   = rev_ff;
      act_in   = act_ff;
      begun_in = begun_ff;
      kind_in  = kind_ff;
      dt_in    = dt_ff;
      fb_in    = fb_ff;
      prog_in  = prog_ff;
      rsp_load = 1'b0;
      case (ctrl.op)
         drp_pkg::OP_ACCEPT: begin
            if (fire) begin
               kind_in = req_chan.kind;
               dt_in   = req_chan.elapsed;
            end
         end
         drp_pkg::OP_START: begin
            wait_in  = wait_new;
            rev_in   = 1'b0;
            begun_in = 1'b1;
            act_in   = start_live;
            pos_in   = start_live ? '0 : len_ff;
         end
         drp_pkg::OP_FINISH: begin
            pos_in   = len_ff;
            wait_in  = '0;
            act_in   = 1'b0;
            begun_in = 1'b1;
         end
         drp_pkg::OP_USE_WAIT: begin
            // delay is eaten first
            wait_in = wait_ff - TIME_BITS'(used_x);
            dt_in   = dt_ff - EB'(used_x);
         end
         drp_pkg::OP_ONCE: begin
            if (sum_x >= len_x) begin
               pos_in = len_ff;
               act_in = 1'b0;
            end else begin
               pos_in = TIME_BITS'(sum_x);
            end
         end
         drp_pkg::OP_ZERO: begin
            pos_in = '0;
            act_in = 1'b0;
         end
         drp_pkg::OP_LOOP_END: begin
            pos_in = div_rem;
         end
         drp_pkg::OP_CLAMP: begin
            // duration lowered below position
            pos_in = (pos_ff > len_ff) ? len_ff : pos_ff;
         end
         drp_pkg::OP_PP_FWD: begin
            if (fwd_fits) begin
               pos_in = TIME_BITS'(sum_x);
            end else begin
               fb_in = 1'b1;
            end
         end
         drp_pkg::OP_PP_BACK: begin
            if (back_fits) begin
               pos_in = TIME_BITS'(pos_x - dt_x);
            end else begin
               fb_in = 1'b0;
            end
         end
         drp_pkg::OP_PP_END: begin
            pos_in = refl_back ? TIME_BITS'(TB1'(len_ff) - refl_r) : TIME_BITS'(refl_r);
            rev_in = refl_back;
         end
         drp_pkg::OP_PROG_SETUP: begin
            if (!begun_ff) begin
               prog_in = '0;
            end else begin
               prog_in = {1'b1, {FRAC_BITS{1'b0}}};
            end
         end
         drp_pkg::OP_PROG_END: begin
            prog_in = div_quo[FRAC_BITS:0];
         end
         drp_pkg::OP_EMIT: begin
            rsp_load = out_free;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         wcfg_ff <= '0;
         mode_ff <= drp_pkg::MODE_ONCE;
      end else if (csr_write) begin
         case (csr_index)
            drp_pkg::REG_RAMP_LENGTH: len_ff  <= csr_data;
            drp_pkg::REG_START_WAIT:  wcfg_ff <= csr_data;
            drp_pkg::REG_REPEAT_MODE: mode_ff <= csr_data[drp_pkg::MODE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // ramp state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         wait_ff      <= '0;
         rev_ff       <= 1'b0;
         act_ff       <= 1'b0;
         begun_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         wait_ff      <= wait_in;
         rev_ff       <= rev_in;
         act_ff       <= act_in;
         begun_ff     <= begun_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      dt_ff   <= dt_in;
      fb_ff   <= fb_in;
      prog_ff <= prog_in;
      if (rsp_load) begin
         rsp_prog_ff  <= prog_in;
         rsp_pos_ff   <= pos_ff;
         rsp_back_ff  <= rev_ff;
         rsp_run_ff   <= act_ff;
         rsp_begun_ff <= begun_ff;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.progress       = rsp_prog_ff;
   assign rsp_chan.position_ticks = rsp_pos_ff;
   assign rsp_chan.going_back     = rsp_back_ff;
   assign rsp_chan.is_running     = rsp_run_ff;
   assign rsp_chan.has_started    = rsp_begun_ff;

endmodule

@@ sim/drp_phase_checker.sv @@
// response checker for the ramp phase generator: tracks the ramp and compares every response
`timescale 1ns / 1ps

module drp_phase_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   drp_req_if                                    req_mon,
   drp_rsp_if                                    rsp_mon,
   input  logic                                  csr_write,
   input  logic [drp_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [drp_pkg::TIME_BITS_DEF-1:0]     csr_data,
   output int                                    fail_count,
   output int                                    outstanding
);
   import drp_pkg::*;

   localparam int TBITS = TIME_BITS_DEF;
   localparam int FBITS = FRAC_BITS_DEF;
   localparam int PBITS = FBITS + 1;
   localparam int NBITS = TBITS + FBITS;

   typedef struct packed {
      logic [PBITS-1:0] progress;
      logic [TBITS-1:0] position_ticks;
      logic             going_back;
      logic             is_running;
      logic             has_started;
   } ramp_phase_type;

   // register copies
   logic [TBITS-1:0]     ramp_len = '0;
   logic [TBITS-1:0]     start_delay = '0;
   logic [MODE_BITS-1:0] mode = '0;

   // ramp state as the block should hold it
   logic [TBITS-1:0]     pos = '0;
   logic [TBITS-1:0]     delay_left = '0;
   logic                 backward = 1'b0;
   logic                 running = 1'b0;
   logic                 started = 1'b0;

   ramp_phase_type       expected_phases[$];
   int                   errors = 0;

   assign fail_count = errors;

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   // travel past an end point, bouncing between the ends
   function automatic void bounce(logic [31:0] travel, logic [31:0] dur, logic first_back);
      logic [31:0] legs;
      logic [31:0] rem;
      logic        back;
      legs = (travel - 32'd1) / dur;
      rem = travel - legs * dur;
      back = legs[0] ? !first_back : first_back;
      pos = back ? TBITS'(dur - rem) : TBITS'(rem);
      backward = back;
   endfunction

   function automatic void launch();
      pos = '0;
      backward = 1'b0;
      started = 1'b1;
      running = (ramp_len != '0) || (delay_left != '0);
      if (!running) pos = ramp_len;
   endfunction

   function automatic void advance_ramp(logic [KIND_BITS-1:0] cmd,
                                        logic [ELAPSED_BITS-1:0] elapsed);
      logic [31:0] dt;
      logic [31:0] dur;
      logic [31:0] p;
      logic [31:0] used;
      dt = 32'(elapsed);
      dur = 32'(ramp_len);
      p = 32'(pos);
      case (cmd)
         KIND_START: begin
            delay_left = start_delay;
            launch();
         end
         KIND_RESTART: begin
            delay_left = '0;
            launch();
         end
         KIND_FINISH: begin
            pos = ramp_len;
            delay_left = '0;
            running = 1'b0;
            started = 1'b1;
         end
         default: begin
            if (!running || dt == 32'd0) return;
            // the delay eats the ticks first
            if (delay_left != '0) begin
               used = (32'(delay_left) < dt) ? 32'(delay_left) : dt;
               delay_left = delay_left - TBITS'(used);
               dt = dt - used;
               if (dt == 32'd0) return;
            end
            if (dur == 32'd0) begin
               pos = '0;
               running = 1'b0;
               return;
            end
            case (mode)
               MODE_LOOP: pos = TBITS'((p + dt) % dur);
               MODE_PING: begin
                  if (p > dur) p = dur;
                  if (backward) begin
                     if (dt <= p) pos = TBITS'(p - dt);
                     else bounce(dt - p, dur, 1'b0);
                  end else if (p + dt <= dur) begin
                     pos = TBITS'(p + dt);
                  end else begin
                     bounce(p + dt - dur, dur, 1'b1);
                  end
               end
               default: begin
                  if (p + dt >= dur) begin
                     pos = ramp_len;
                     running = 1'b0;
                  end else begin
                     pos = TBITS'(p + dt);
                  end
               end
            endcase
         end
      endcase
   endfunction

   always @(posedge clock) begin
      ramp_phase_type want;
      if (reset) begin
         ramp_len = '0;
         start_delay = '0;
         mode = '0;
         pos = '0;
         delay_left = '0;
         backward = 1'b0;
         running = 1'b0;
         started = 1'b0;
         expected_phases.delete();
         outstanding <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_phases.size() == 0) begin
               $error("response with no transaction outstanding");
               errors++;
            end else begin
               want = expected_phases.pop_front();
               compare_field("progress", 32'(want.progress), 32'(rsp_mon.progress));
               compare_field("position_ticks", 32'(want.position_ticks),
                             32'(rsp_mon.position_ticks));
               compare_field("going_back", 32'(want.going_back), 32'(rsp_mon.going_back));
               compare_field("is_running", 32'(want.is_running), 32'(rsp_mon.is_running));
               compare_field("has_started", 32'(want.has_started), 32'(rsp_mon.has_started));
            end
         end
         if (csr_write) begin
            case (csr_index)
               REG_RAMP_LENGTH: ramp_len = csr_data;
               REG_START_WAIT:  start_delay = csr_data;
               REG_REPEAT_MODE: mode = csr_data[MODE_BITS-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            advance_ramp(req_mon.kind, req_mon.elapsed);
            want.position_ticks = pos;
            want.going_back = backward;
            want.is_running = running;
            want.has_started = started;
            if (!started) want.progress = '0;
            else if (pos >= ramp_len) want.progress = PBITS'(1 << FBITS);
            else want.progress = PBITS'({pos, {FBITS{1'b0}}} / NBITS'(ramp_len));
            expected_phases.push_back(want);
         end
         outstanding <= expected_phases.size();
      end
   end

endmodule

@@ sim/tb_delayed_ramp_phase_generator_core.sv @@
// testbench top: drives commands and registers of the ramp phase generator and reports the verdict
`timescale 1ns / 1ps

module tb_delayed_ramp_phase_generator_core;
   import drp_pkg::*;

   localparam int TBITS = TIME_BITS_DEF;
   // index with no register behind it, writes must be ignored
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE = 2'd3;
   // mode code with no mode of its own, runs as once
   localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;
   localparam logic [TBITS-1:0] TICKS_MAX = '1;
   localparam int RANDOM_PHASES = 32;
   localparam int PHASE_COMMANDS = 47;

   logic                      clock;
   logic                      reset;
   logic                      csr_write;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [TBITS-1:0]          csr_data;
   int                        fail_count;
   int                        outstanding;
   int                        sender_idle = 0;     // percent of cycles the command side holds back
   int                        receiver_stall = 0;  // percent of cycles the response side stalls

   drp_req_if req_chan();
   drp_rsp_if rsp_chan();

   delayed_ramp_phase_generator_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // predicts and checks every response, counts the mismatches
   drp_phase_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard limit on the whole run, far beyond the slowest correct run
   initial begin
      #(20_000_000);
      $display("[delayed_ramp_phase_generator_core] ERROR");
      $finish;
   end

   // response side: ready drawn afresh every cycle
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= receiver_stall);
      end
   end

   // one command transaction; valid stays high into the next command unless a gap is drawn
   task automatic send_cmd(logic [KIND_BITS-1:0] cmd, logic [ELAPSED_BITS-1:0] ticks);
      while ($urandom_range(99) < sender_idle) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.kind    <= cmd;
      req_chan.elapsed <= ticks;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // register write, only once every response is back and the block is idle
   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [TBITS-1:0] value);
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic configure(logic [TBITS-1:0] len, logic [TBITS-1:0] delay,
                            logic [TBITS-1:0] mode_word);
      write_reg(REG_RAMP_LENGTH, len);
      write_reg(REG_START_WAIT, delay);
      write_reg(REG_REPEAT_MODE, mode_word);
   endtask

   initial begin
      logic [TBITS-1:0]        len;
      logic [TBITS-1:0]        delay;
      logic [KIND_BITS-1:0]    cmd;
      logic [ELAPSED_BITS-1:0] ticks;
      int                      roll;
      int                      near;

      req_chan.valid   <= 1'b0;
      req_chan.kind    <= KIND_TICK;
      req_chan.elapsed <= '0;
      csr_write        <= 1'b0;
      csr_index        <= REG_RAMP_LENGTH;
      csr_data         <= '0;
      reset            <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part, no idling ----

      // nothing started yet: progress reads zero and ticks do nothing
      send_cmd(KIND_TICK, '0);
      send_cmd(KIND_TICK, '1);
      // zero duration after reset: finish and start arrive at once
      send_cmd(KIND_FINISH, '0);
      send_cmd(KIND_START, '1);

      configure(24'd1000, 24'd300, TBITS'(MODE_ONCE));
      send_cmd(KIND_START, '0);
      send_cmd(KIND_TICK, 16'd100);   // inside the delay
      send_cmd(KIND_TICK, 16'd250);   // delay runs out mid transaction, 50 ticks move on
      send_cmd(KIND_TICK, '0);
      send_cmd(KIND_TICK, '1);        // saturates at the end and stops
      send_cmd(KIND_TICK, 16'd5);     // stopped, ignored
      send_cmd(KIND_RESTART, '0);
      send_cmd(KIND_TICK, 16'd999);
      send_cmd(KIND_FINISH, '0);

      // zero duration with a delay: the tick spends the delay, then stops at zero
      configure('0, 24'd10, TBITS'(MODE_LOOP));
      send_cmd(KIND_START, '0);
      send_cmd(KIND_TICK, 16'd15);

      // ping-pong end points
      configure(24'd100, '0, TBITS'(MODE_PING));
      send_cmd(KIND_RESTART, '0);
      send_cmd(KIND_TICK, 16'd100);   // lands on the end, still heading forward
      send_cmd(KIND_TICK, 16'd100);   // bounces, lands on zero still heading back
      send_cmd(KIND_TICK, '1);        // many bounces

      // duration lowered under the position, in each mode
      write_reg(REG_RAMP_LENGTH, 24'd60000);
      send_cmd(KIND_RESTART, '0);
      send_cmd(KIND_TICK, 16'd40000);
      write_reg(REG_RAMP_LENGTH, 24'd300);
      send_cmd(KIND_TICK, 16'd7);     // ping-pong pins the position at the end first
      write_reg(REG_RAMP_LENGTH, 24'd200);
      write_reg(REG_REPEAT_MODE, {22'h15A5A5, MODE_LOOP});  // upper bits ignored
      send_cmd(KIND_TICK, 16'd3);     // loop wraps from above the end
      write_reg(REG_RAMP_LENGTH, 24'd50);
      write_reg(REG_REPEAT_MODE, TBITS'(MODE_SPARE));
      send_cmd(KIND_TICK, 16'd1);     // spare mode code saturates like once
      write_reg(REG_SPARE, TBITS'($urandom));

      // widest duration and delay
      configure(TICKS_MAX, TICKS_MAX, TBITS'(MODE_PING));
      send_cmd(KIND_START, '0);
      send_cmd(KIND_TICK, '1);
      send_cmd(KIND_RESTART, '0);
      send_cmd(KIND_TICK, '1);

      // ---- random part: a fresh setting per phase, idling pattern rotating ----
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph % 4)
            0: begin sender_idle = 0;  receiver_stall <= 0;  end
            1: begin sender_idle = 85; receiver_stall <= 0;  end
            2: begin sender_idle = 0;  receiver_stall <= 85; end
            default: begin sender_idle = 13; receiver_stall <= 13; end
         endcase

         // short ramps mostly, so wraps and bounces happen often
         roll = $urandom_range(99);
         if (roll < 8) len = '0;
         else if (roll < 55) len = TBITS'($urandom_range(1, 64));
         else if (roll < 80) len = TBITS'($urandom_range(65, 70000));
         else len = TBITS'($urandom);

         roll = $urandom_range(99);
         if (roll < 40) delay = '0;
         else if (roll < 92) delay = TBITS'($urandom_range(1, 100));
         else delay = TBITS'($urandom);

         // random mode code, upper bits of the write random as well
         configure(len, delay, TBITS'($urandom));

         repeat (PHASE_COMMANDS) begin
            roll = $urandom_range(99);
            if (roll < 70) cmd = KIND_TICK;
            else if (roll < 82) cmd = KIND_START;
            else if (roll < 92) cmd = KIND_RESTART;
            else cmd = KIND_FINISH;

            // elapsed: zero, small steps, about one duration, or anything
            roll = $urandom_range(99);
            if (roll < 8) begin
               ticks = '0;
            end else if (roll < 50) begin
               ticks = ELAPSED_BITS'($urandom_range(1, 40));
            end else if (roll < 75) begin
               near = (len > TBITS'(65534)) ? 65534 : int'(len);
               near = near + int'($urandom_range(0, 2)) - 1;
               if (near < 0) near = 0;
               ticks = ELAPSED_BITS'(near);
            end else begin
               ticks = ELAPSED_BITS'($urandom);
            end
            send_cmd(cmd, ticks);
         end
      end

      // drain, then give the block time to show any stray response
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (400) @(posedge clock);
      if (fail_count == 0) $display("[delayed_ramp_phase_generator_core] OK");
      else $display("[delayed_ramp_phase_generator_core] ERROR");
      $finish;
   end

endmodule
